>>> hdl/pgq_pkg.sv
// ----------------------------------------------------------------------------
// pgq_pkg
// Shared types, constants and helpers of the pointer gesture quantizer.
// ----------------------------------------------------------------------------
package pgq_pkg;

	// field and state widths
	localparam int DELTA_BITS = 16;
	localparam int TOT_W      = 32;
	localparam int STEP_W     = 15;
	localparam int WAIT_W     = 16;
	localparam int ELAPSED_W  = 17;
	localparam int TAP_W      = 8;
	localparam int DIV_CNT_W  = $clog2(TOT_W);
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// result queue, at most three results per item
	localparam int QDEPTH = 3;
	localparam int QCNT_W = 2;

	localparam logic [STEP_W-1:0]    STEP_RESET  = STEP_W'(100);
	localparam logic [TAP_W-1:0]     TAP_CAP     = {TAP_W{1'b1}};
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

	typedef enum logic [1:0] {
		REQ_MOVE  = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_START = 2'd2,
		REQ_STOP  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ACT_PRESS   = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_RIGHT   = 3'd2,
		ACT_LEFT    = 3'd3,
		ACT_DOWN    = 3'd4,
		ACT_UP      = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		PRE_NONE    = 2'd0,
		PRE_START   = 2'd1,
		PRE_FIRST   = 2'd2,
		PRE_INSTEAD = 2'd3
	} pre_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_DISTANCE = 2'd0,
		CFG_ANGLE_SNAP    = 2'd1,
		CFG_PRE_MODE      = 2'd2,
		CFG_WAIT_MS       = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIVIDE,
		ST_APPLY,
		ST_EMIT
	} state_t;

	typedef struct packed {
		req_t                   req_type;
		logic [DELTA_BITS-1:0]  delta_x;
		logic [DELTA_BITS-1:0]  delta_y;
	} in_item_t;

	typedef struct packed {
		act_t             action;
		logic [TAP_W-1:0] tap_count;
		logic             last;
	} out_item_t;

	typedef struct packed {
		act_t             action;
		logic [TAP_W-1:0] tap_count;
	} q_ent_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic div_start;
		logic second;
		logic apply;
		logic emit;
	} pgq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic move_go;
		logic div_busy;
		logic drained;
	} pgq_sts_t;

	// saturate a sum with one guard bit to the signed total range
	function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W:0] s);
		logic [TOT_W-1:0] r;
		r = s[TOT_W-1:0];
		if (s[TOT_W] != s[TOT_W-1]) begin
			r = s[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> hdl/pgq_div.sv
// ----------------------------------------------------------------------------
// pgq_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned total
// magnitude by step distance.
// ----------------------------------------------------------------------------
module pgq_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pgq_pkg::TOT_W-1:0]    dividend,
	input  logic [pgq_pkg::STEP_W-1:0]   divisor,
	output logic                         busy,
	output logic [pgq_pkg::TOT_W-1:0]    quotient,
	output logic [pgq_pkg::STEP_W-1:0]   remainder
);
	import pgq_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TOT_W-1:0]     quo_q;
	logic [STEP_W-1:0]    rem_q;
	logic [STEP_W-1:0]    div_q;
	logic [STEP_W:0]      trial;
	logic [STEP_W:0]      diff;
	logic                 ge;

	// trial subtraction of one step
	always_comb begin
		trial = {rem_q, quo_q[TOT_W-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(TOT_W-1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// shifting dividend, partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TOT_W-2:0], ge};
			rem_q <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hdl/pgq_dp.sv
// ----------------------------------------------------------------------------
// pgq_dp
// Datapath: configuration, axis totals, gesture flags, divider, result
// queue and output register.
// ----------------------------------------------------------------------------
module pgq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pgq_pkg::pgq_cmd_t                 cmd,
	output pgq_pkg::pgq_sts_t                 sts,
	input  pgq_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pgq_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [pgq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pgq_pkg::*;

	// configuration
	logic [STEP_W-1:0] step_q;
	logic              snap_q;
	pre_mode_t         pre_mode_q;
	logic [WAIT_W-1:0] wait_ms_q;

	// gesture state
	logic [TOT_W-1:0]     total_x_q;
	logic [TOT_W-1:0]     total_y_q;
	logic                 active_q;
	logic                 pre_pressed_q;
	logic                 wait_active_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic                 x_first_q;

	// result queue and output register
	q_ent_t            slot_q [QDEPTH];
	logic [QCNT_W-1:0] qcnt_q;
	logic [QCNT_W-1:0] rd_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// move evaluation
	logic [DELTA_BITS-1:0] dx, dy;
	logic                  dx_neg, dy_neg;
	logic                  wait_block, move_go;
	logic [TOT_W:0]        dx_ext, dy_ext;
	logic [TOT_W-1:0]      tx_base, ty_base;
	logic [TOT_W-1:0]      sum_x, sum_y;
	logic [DELTA_BITS:0]   ax, ay;

	// axis step
	logic              sel_y;
	logic [TOT_W-1:0]  cur_tot;
	logic              cur_neg;
	logic [TOT_W-1:0]  dividend;
	logic [STEP_W-1:0] divisor;
	logic              div_busy;
	logic [TOT_W-1:0]  quo;
	logic [STEP_W-1:0] rem;
	logic [TAP_W-1:0]  cnt0, cnt1;
	logic              tap_nz, do_press, do_dir;
	logic [TOT_W-1:0]  rem_ext, new_tot;
	act_t              dir_act;

	// start and stop
	logic push_start, push_stop;

	// queue writes
	logic [QCNT_W-1:0] push_n;
	logic [QCNT_W-1:0] wbase;
	q_ent_t            ent_a, ent_b;
	logic              load;

	// move gating, sign clear and saturating add
	always_comb begin
		dx         = in_data.delta_x;
		dy         = in_data.delta_y;
		dx_neg     = dx[DELTA_BITS-1];
		dy_neg     = dy[DELTA_BITS-1];
		wait_block = (wait_ms_q != '0) && wait_active_q
			&& (elapsed_q <= {1'b0, wait_ms_q});
		move_go    = (in_data.req_type == REQ_MOVE) && ((dx != '0) || (dy != '0))
			&& active_q && !wait_block;
		dx_ext     = {{(TOT_W+1-DELTA_BITS){dx_neg}}, dx};
		dy_ext     = {{(TOT_W+1-DELTA_BITS){dy_neg}}, dy};
		tx_base    = (total_x_q[TOT_W-1] == dx_neg) ? total_x_q : '0;
		ty_base    = (total_y_q[TOT_W-1] == dy_neg) ? total_y_q : '0;
		sum_x      = sat_tot({tx_base[TOT_W-1], tx_base} + dx_ext);
		sum_y      = sat_tot({ty_base[TOT_W-1], ty_base} + dy_ext);
		ax         = dx_neg ? (~{dx_neg, dx} + 1'b1) : {1'b0, dx};
		ay         = dy_neg ? (~{dy_neg, dy} + 1'b1) : {1'b0, dy};
	end

	// start and stop results
	always_comb begin
		push_start = (in_data.req_type == REQ_START) && !active_q
			&& (pre_mode_q == PRE_START) && !pre_pressed_q;
		push_stop  = (in_data.req_type == REQ_STOP) && active_q
			&& (pre_mode_q != PRE_NONE) && pre_pressed_q;
	end

	// axis selection and divider operands
	always_comb begin
		sel_y    = cmd.second ? x_first_q : !x_first_q;
		cur_tot  = sel_y ? total_y_q : total_x_q;
		cur_neg  = cur_tot[TOT_W-1];
		dividend = cur_neg ? (~cur_tot + 1'b1) : cur_tot;
		divisor  = (step_q == '0) ? STEP_W'(1) : step_q;
	end

	pgq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.busy      (div_busy),
		.quotient  (quo),
		.remainder (rem)
	);

	// tap count, pre press and signed remainder of one axis
	always_comb begin
		cnt0     = (quo[TOT_W-1:TAP_W] != '0) ? TAP_CAP : quo[TAP_W-1:0];
		tap_nz   = cnt0 != '0;
		do_press = tap_nz && (pre_mode_q != PRE_NONE) && !pre_pressed_q;
		cnt1     = (do_press && (pre_mode_q == PRE_INSTEAD)) ? cnt0 - 1'b1 : cnt0;
		do_dir   = tap_nz && (cnt1 != '0);
		rem_ext  = {{(TOT_W-STEP_W){1'b0}}, rem};
		new_tot  = cur_neg ? (~rem_ext + 1'b1) : rem_ext;
		if (sel_y) begin
			dir_act = cur_neg ? ACT_UP : ACT_DOWN;
		end else begin
			dir_act = cur_neg ? ACT_LEFT : ACT_RIGHT;
		end
	end

	// queue push selection
	always_comb begin
		push_n = '0;
		wbase  = qcnt_q;
		ent_a  = '{action: ACT_PRESS, tap_count: '0};
		ent_b  = '{action: dir_act, tap_count: cnt1};
		if (cmd.accept) begin
			wbase = '0;
			if (push_start || push_stop) begin
				push_n = QCNT_W'(1);
			end
			if (push_stop) begin
				ent_a.action = ACT_RELEASE;
			end
		end else if (cmd.apply) begin
			push_n = QCNT_W'(do_press) + QCNT_W'(do_dir);
			if (!do_press) begin
				ent_a = ent_b;
			end
		end
	end

	assign load = cmd.emit && (rd_q != qcnt_q) && (!out_valid_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= STEP_RESET;
			snap_q     <= 1'b0;
			pre_mode_q <= PRE_NONE;
			wait_ms_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_STEP_DISTANCE: step_q     <= cfg_data[STEP_W-1:0];
				CFG_ANGLE_SNAP:    snap_q     <= cfg_data[0];
				CFG_PRE_MODE:      pre_mode_q <= pre_mode_t'(cfg_data[1:0]);
				CFG_WAIT_MS:       wait_ms_q  <= cfg_data[WAIT_W-1:0];
			endcase
		end
	end

	// axis totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_x_q <= '0;
			total_y_q <= '0;
			x_first_q <= 1'b1;
		end else if (cmd.accept) begin
			if (move_go) begin
				total_x_q <= sum_x;
				total_y_q <= sum_y;
				x_first_q <= ax >= ay;
			end else if ((in_data.req_type == REQ_STOP) && active_q) begin
				total_x_q <= '0;
				total_y_q <= '0;
			end
		end else if (cmd.apply && tap_nz) begin
			if (sel_y) begin
				total_y_q <= new_tot;
				if (snap_q) begin
					total_x_q <= '0;
				end
			end else begin
				total_x_q <= new_tot;
				if (snap_q) begin
					total_y_q <= '0;
				end
			end
		end
	end

	// gesture flags and wait window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			pre_pressed_q <= 1'b0;
			wait_active_q <= 1'b0;
			elapsed_q     <= '0;
		end else if (cmd.accept) begin
			unique case (in_data.req_type)
				REQ_MOVE: begin
					if (move_go && (wait_ms_q != '0)) begin
						wait_active_q <= 1'b0;
					end
				end
				REQ_TICK: begin
					if (wait_active_q && (elapsed_q != ELAPSED_MAX)) begin
						elapsed_q <= elapsed_q + 1'b1;
					end
				end
				REQ_START: begin
					active_q <= 1'b1;
					if (push_start) begin
						pre_pressed_q <= 1'b1;
					end
				end
				REQ_STOP: begin
					active_q <= 1'b0;
					if (push_stop) begin
						pre_pressed_q <= 1'b0;
						wait_active_q <= 1'b0;
					end
				end
			endcase
		end else if (cmd.apply && do_press) begin
			pre_pressed_q <= 1'b1;
			if (pre_mode_q == PRE_INSTEAD) begin
				wait_active_q <= 1'b1;
				elapsed_q     <= '0;
			end
		end
	end

	// queue counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
			rd_q   <= '0;
		end else if (cmd.accept) begin
			qcnt_q <= push_n;
			rd_q   <= '0;
		end else begin
			if (cmd.apply) begin
				qcnt_q <= qcnt_q + push_n;
			end
			if (load) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	// queue entries
	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if ((push_n != '0) && (wbase == QCNT_W'(i))) begin
				slot_q[i] <= ent_a;
			end else if ((push_n == QCNT_W'(2)) && (wbase + 1'b1 == QCNT_W'(i))) begin
				slot_q[i] <= ent_b;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.action    <= slot_q[rd_q].action;
			out_q.tap_count <= slot_q[rd_q].tap_count;
			out_q.last      <= (rd_q + 1'b1) == qcnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_data     = out_q;
	assign sts.move_go  = move_go;
	assign sts.div_busy = div_busy;
	assign sts.drained  = rd_q == qcnt_q;

endmodule

>>> hdl/pgq_ctrl.sv
// ----------------------------------------------------------------------------
// pgq_ctrl
// Controller: sequences input transfer, two axis divisions and result
// delivery.
// ----------------------------------------------------------------------------
module pgq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pgq_pkg::pgq_sts_t  sts,
	output pgq_pkg::pgq_cmd_t  cmd
);
	import pgq_pkg::*;

	state_t state_q, state_d;
	logic   second_q, second_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d       = state_q;
		second_d      = second_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.second    = second_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					second_d   = 1'b0;
					state_d    = sts.move_go ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (!sts.div_busy) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				if (second_q) begin
					state_d = ST_EMIT;
				end else begin
					second_d = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.drained) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/pointer_gesture_quantizer.sv
// ----------------------------------------------------------------------------
// pointer_gesture_quantizer
// Turns pointer deltas into directional tap bursts with optional pre press.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A tick, start or stop, or a move that is
// dropped, goes from the idle state straight to result delivery. A move that
// is acted on runs both axes through one shared radix-2 divider, each axis in
// turn through operand load, the 32 quotient bits, a state that sees the
// divider finish, and the update. An item gives up to three results, a start
// or stop at most one. Each result moves to the output register on its own,
// and a stall on the output holds back the later results of the same item
// while an earlier one waits. The input is ready again once the last result
// of an item sits in the output register, so a waiting result does not hold
// off the next input transfer. No clearing pass after reset.
module pointer_gesture_quantizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pgq_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pgq_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [pgq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pgq_pkg::*;

	pgq_cmd_t cmd;
	pgq_sts_t sts;

	// sequencer
	pgq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// totals, divider and result path
	pgq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> tb/sv/pointer_gesture_quantizer_checker.sv
// ----------------------------------------------------------------------------
// pointer_gesture_quantizer_checker
// Watches the request, result and register ports of the gesture quantizer,
// predicts the tap bursts of every accepted request and compares each result
// transfer field by field against the oldest predicted action.
// ----------------------------------------------------------------------------
module pointer_gesture_quantizer_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  pgq_pkg::in_item_t                 in_data,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  pgq_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [pgq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pgq_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                errors,
	output int                                pending,
	output int                                results_seen
);
	import pgq_pkg::*;

	// shadow copy of the registers
	logic [STEP_W-1:0]    step_dist;
	logic                 snap_en;
	pre_mode_t            pre_sel;
	logic [WAIT_W-1:0]    wait_len;

	// shadow copy of the gesture state
	longint               tot_x;
	longint               tot_y;
	bit                   gesture_on;
	bit                   press_held;
	bit                   hold_off;
	logic [ELAPSED_W-1:0] hold_ms;

	// actions predicted but not yet seen, and those of the current request
	out_item_t            pending_actions[$];
	out_item_t            burst[$];
	int                   fail_cnt;
	int                   seen_cnt;

	function automatic longint clamp_total(longint v);
		if (v > longint'(32'sh7FFFFFFF))
			return longint'(32'sh7FFFFFFF);
		if (v < longint'(32'sh80000000))
			return longint'(32'sh80000000);
		return v;
	endfunction

	task automatic add_action(act_t act, logic [TAP_W-1:0] taps);
		out_item_t r;
		r.action    = act;
		r.tap_count = taps;
		r.last      = 1'b0;
		burst = {burst, r};
	endtask

	// divide one axis total into taps, keep the remainder
	task automatic axis_taps(bit on_y);
		longint divisor;
		longint t;
		longint q;
		int     taps;
		act_t   dir;
		divisor = (step_dist == '0) ? 1 : longint'(step_dist);
		t = on_y ? tot_y : tot_x;
		q = t / divisor;
		if (q < 0)
			q = -q;
		taps = (q > 255) ? 255 : int'(q);
		if (taps == 0)
			return;
		if (on_y) begin
			tot_y = t % divisor;
			if (snap_en)
				tot_x = 0;
			dir = (t > 0) ? ACT_DOWN : ACT_UP;
		end else begin
			tot_x = t % divisor;
			if (snap_en)
				tot_y = 0;
			dir = (t > 0) ? ACT_RIGHT : ACT_LEFT;
		end
		// pre press goes out once per gesture, ahead of the first burst
		if (pre_sel != PRE_NONE && !press_held) begin
			press_held = 1'b1;
			add_action(ACT_PRESS, '0);
			if (pre_sel == PRE_INSTEAD) begin
				taps     = taps - 1;
				hold_off = 1'b1;
				hold_ms  = '0;
			end
		end
		if (taps != 0)
			add_action(dir, TAP_W'(taps));
	endtask

	// predicted actions of one request, last flag on the final one
	task automatic quantize_item(in_item_t it);
		longint    dx;
		longint    dy;
		longint    ax;
		longint    ay;
		out_item_t tail;
		burst.delete();
		case (it.req_type)
			REQ_TICK: begin
				if (hold_off && hold_ms != ELAPSED_MAX)
					hold_ms = hold_ms + 1'b1;
			end
			REQ_START: begin
				if (!gesture_on) begin
					gesture_on = 1'b1;
					if (pre_sel == PRE_START && !press_held) begin
						press_held = 1'b1;
						add_action(ACT_PRESS, '0);
					end
				end
			end
			REQ_STOP: begin
				if (gesture_on) begin
					gesture_on = 1'b0;
					if (pre_sel != PRE_NONE && press_held) begin
						press_held = 1'b0;
						hold_off   = 1'b0;
						add_action(ACT_RELEASE, '0);
					end
					tot_x = 0;
					tot_y = 0;
				end
			end
			default: begin
				dx = longint'($signed(it.delta_x));
				dy = longint'($signed(it.delta_y));
				if ((dx != 0 || dy != 0) && gesture_on &&
				    !(wait_len != '0 && hold_off && hold_ms <= wait_len)) begin
					if (wait_len != '0)
						hold_off = 1'b0;
					// a change of direction restarts the axis total
					if ((tot_x < 0) != (dx < 0))
						tot_x = 0;
					if ((tot_y < 0) != (dy < 0))
						tot_y = 0;
					tot_x = clamp_total(tot_x + dx);
					tot_y = clamp_total(tot_y + dy);
					ax = (dx < 0) ? -dx : dx;
					ay = (dy < 0) ? -dy : dy;
					if (ax >= ay) begin
						axis_taps(1'b0);
						axis_taps(1'b1);
					end else begin
						axis_taps(1'b1);
						axis_taps(1'b0);
					end
				end
			end
		endcase
		if (burst.size() > 0) begin
			tail = burst[burst.size() - 1];
			tail.last = 1'b1;
			burst[burst.size() - 1] = tail;
		end
		pending_actions = {pending_actions, burst};
	endtask

	// transfer monitor, predictor and compare
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			step_dist  = STEP_RESET;
			snap_en    = 1'b0;
			pre_sel    = PRE_NONE;
			wait_len   = '0;
			tot_x      = 0;
			tot_y      = 0;
			gesture_on = 1'b0;
			press_held = 1'b0;
			hold_off   = 1'b0;
			hold_ms    = '0;
			fail_cnt   = 0;
			seen_cnt   = 0;
			pending_actions.delete();
			errors       <= 0;
			pending      <= 0;
			results_seen <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_STEP_DISTANCE: step_dist = cfg_data[STEP_W-1:0];
					CFG_ANGLE_SNAP:    snap_en   = cfg_data[0];
					CFG_PRE_MODE:      pre_sel   = pre_mode_t'(cfg_data[1:0]);
					default:           wait_len  = cfg_data[WAIT_W-1:0];
				endcase
			end

			// result transfer against the oldest predicted action
			if (out_valid && out_ready) begin
				seen_cnt++;
				if (pending_actions.size() == 0) begin
					fail_cnt++;
					$display("%0t: unexpected result, expected none, actual action %0d taps %0d last %0d",
						$time, out_data.action, out_data.tap_count, out_data.last);
				end else begin
					want = pending_actions.pop_front();
					if (out_data.action !== want.action) begin
						fail_cnt++;
						$display("%0t: action mismatch, expected %0d, actual %0d",
							$time, want.action, out_data.action);
					end
					if (out_data.tap_count !== want.tap_count) begin
						fail_cnt++;
						$display("%0t: tap count mismatch, expected %0d, actual %0d",
							$time, want.tap_count, out_data.tap_count);
					end
					if (out_data.last !== want.last) begin
						fail_cnt++;
						$display("%0t: last flag mismatch, expected %0d, actual %0d",
							$time, want.last, out_data.last);
					end
				end
			end

			// request transfer
			if (in_valid && in_ready)
				quantize_item(in_data);

			errors       <= fail_cnt;
			pending      <= pending_actions.size();
			results_seen <= seen_cnt;
		end
	end

endmodule

>>> tb/sv/pointer_gesture_quantizer_test.sv
// ----------------------------------------------------------------------------
// pointer_gesture_quantizer_test
// Drives the gesture quantizer with directed and random gesture sequences
// over several register settings, with random idle and stall bursts, and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module pointer_gesture_quantizer_test;
	import pgq_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 14;
	localparam int PHASES       = 5;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int results_seen;
	int items_sent;
	int settings_used;
	int cycles = 0;
	bit idle_on;

	pointer_gesture_quantizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pointer_gesture_quantizer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d actions outstanding", cycles, pending);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side stalls in random bursts
	initial begin : result_stall
		int stall;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one request transfer, optionally after an idle burst
	task automatic send_item(req_t req, logic [15:0] dx, logic [15:0] dy);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{req_type: req, delta_x: dx, delta_y: dy};
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// wait until every predicted action is out and the divider is done
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write all four registers back to back
	task automatic configure(logic [15:0] step, logic snap, pre_mode_t pre, logic [15:0] wms);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_STEP_DISTANCE;
		cfg_data  <= step;
		@(posedge clk);
		cfg_index <= CFG_ANGLE_SNAP;
		cfg_data  <= {15'd0, snap};
		@(posedge clk);
		cfg_index <= CFG_PRE_MODE;
		cfg_data  <= {14'd0, pre};
		@(posedge clk);
		cfg_index <= CFG_WAIT_MS;
		cfg_data  <= wms;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// delta mix: full range, zero, tiny, or around the step distance
	function automatic logic [15:0] pick_delta(int span);
		int v;
		case ($urandom_range(0, 5))
			0:       v = int'($urandom);
			1:       v = 0;
			2:       v = int'($urandom_range(0, 6)) - 3;
			default: v = int'($urandom_range(0, 2 * span)) - span;
		endcase
		return v[15:0];
	endfunction

	// stimulus
	initial begin : stimulus
		int        step;
		int        span;
		int        moves;
		int        phase_end;
		logic      snap;
		pre_mode_t pre;
		int        wms;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		idle_on   = 1'b1;
		items_sent    = 0;
		settings_used = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: inactive requests, repeated start, zero move, caps
		send_item(REQ_MOVE, 16'd50, 16'd50);
		send_item(REQ_STOP, 16'h0, 16'h0);
		send_item(REQ_START, 16'h0, 16'h0);
		send_item(REQ_START, 16'hFFFF, 16'hFFFF);
		send_item(REQ_MOVE, 16'h0, 16'h0);
		send_item(REQ_MOVE, 16'd250, -16'sd130);
		send_item(REQ_MOVE, 16'h8000, 16'h7FFF);
		send_item(REQ_TICK, 16'h0, 16'h0);
		send_item(REQ_STOP, 16'h0, 16'h0);
		settle();

		// zero step, snap, press instead of first tap, short wait window
		configure(16'd0, 1'b1, PRE_INSTEAD, 16'd2);
		send_item(REQ_START, 16'h0, 16'h0);
		send_item(REQ_MOVE, 16'd1, 16'd0);
		send_item(REQ_MOVE, 16'd5, 16'd5);
		repeat (3) send_item(REQ_TICK, 16'h1234, 16'hEDCB);
		send_item(REQ_MOVE, -16'sd3, 16'd7);
		send_item(REQ_MOVE, 16'h7FFF, 16'h8000);
		send_item(REQ_STOP, 16'h0, 16'h0);
		settle();

		// widest step, press at start, longest wait
		configure(16'h7FFF, 1'b0, PRE_START, 16'hFFFF);
		send_item(REQ_START, 16'h0, 16'h0);
		send_item(REQ_MOVE, 16'h7FFF, 16'h7FFF);
		send_item(REQ_MOVE, 16'h8000, 16'hFFFF);
		send_item(REQ_STOP, 16'h0, 16'h0);
		settle();

		// press with first burst
		configure(16'd7, 1'b1, PRE_FIRST, 16'd0);
		send_item(REQ_START, 16'h0, 16'h0);
		send_item(REQ_MOVE, 16'd20, -16'sd3);
		send_item(REQ_STOP, 16'h0, 16'h0);
		settle();

		// random phases of well-formed gestures with some noise
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					step = 1; snap = 1'b1; pre = PRE_INSTEAD; wms = 0;
				end
				1: begin
					step = 32767; snap = 1'b0; pre = PRE_FIRST; wms = 3;
				end
				default: begin
					step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767)
						: $urandom_range(1, 200);
					snap = 1'($urandom_range(0, 1));
					pre  = pre_mode_t'($urandom_range(0, 3));
					wms  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 6) : 0;
				end
			endcase
			idle_on = (p < PHASES - 1);
			configure(16'(step), snap, pre, 16'(wms));
			span = (step * 3 > 32767) ? 32767 : step * 3;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				moves = $urandom_range(2, 8);
				send_item(REQ_START, 16'($urandom), 16'($urandom));
				for (int k = 0; k < moves; k++) begin
					case ($urandom_range(0, 9))
						0, 1: send_item(REQ_TICK, 16'($urandom), 16'($urandom));
						2: send_item(req_t'($urandom_range(0, 3)), 16'($urandom),
							16'($urandom));
						default: send_item(REQ_MOVE, pick_delta(span), pick_delta(span));
					endcase
				end
				send_item(REQ_STOP, 16'($urandom), 16'($urandom));
			end
			settle();
		end

		$display("covered %0d request transfers over %0d register settings, %0d results checked",
			items_sent, settings_used, results_seen);
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
